@@ src/srpb_pkg.sv @@
// Shared types and constants for the sparse row pointer builder.
// Used by every module of the block; depends on nothing else.
package srpb_pkg;

    localparam int COORD_W         = 16;
    localparam int SLOT_W          = 6;
    localparam int PTR_W           = 16;
    localparam int AXIS_W          = 2;
    localparam int CFG_ADDR_W      = 1;
    localparam int CFG_DATA_W      = 6;
    localparam int IN_DATA_W       = 48;
    localparam int OUT_DATA_W      = 24;

    localparam int DEF_MAX_ROWS    = 32;
    localparam int DEF_COUNT_WIDTH = 16;
    localparam int DEF_QUEUE_DEPTH = 4;

    localparam logic [SLOT_W-1:0] NUM_ROWS_RESET = SLOT_W'(32);

    localparam logic [AXIS_W-1:0] AXIS_I = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_J = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_K = 2'd2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_NUM_ROWS = 1'b0,
        REG_KEY_AXIS = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [SLOT_W-1:0] num_rows;
        logic [AXIS_W-1:0] key_axis;
    } cfg_t;

    // One run of results: slots start..stop, pointer ptr_a up to and
    // including split, ptr_b above it.
    typedef struct packed {
        logic [SLOT_W-1:0] start;
        logic [SLOT_W-1:0] stop;
        logic [SLOT_W-1:0] split;
        logic [PTR_W-1:0]  ptr_a;
        logic [PTR_W-1:0]  ptr_b;
        logic              bad;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ src/srpb_front.sv @@
// Front end: accepts tuples, checks the key and turns each tuple that yields results into a run command.
// Depends on srpb_pkg.
module srpb_front #(
    parameter int MAX_ROWS    = srpb_pkg::DEF_MAX_ROWS,
    parameter int COUNT_WIDTH = srpb_pkg::DEF_COUNT_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  srpb_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [srpb_pkg::COORD_W-1:0]  coord_i,
    input  logic [srpb_pkg::COORD_W-1:0]  coord_j,
    input  logic [srpb_pkg::COORD_W-1:0]  coord_k,
    input  logic                          last_item,
    input  srpb_pkg::q_status_t           q_status,
    output logic                          push,
    output srpb_pkg::cmd_t                cmd
);
    import srpb_pkg::*;

    logic [SLOT_W-1:0]      next_slot_reg, next_slot_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [SLOT_W-1:0]      rows;
    logic [COORD_W-1:0]     key;
    logic                   bad;
    logic                   accept;
    logic [PTR_W+COUNT_WIDTH-1:0] ext_a, ext_b;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (cfg.num_rows == '0)
            rows = SLOT_W'(1);
        else if (cfg.num_rows > SLOT_W'(MAX_ROWS))
            rows = SLOT_W'(MAX_ROWS);
        else
            rows = cfg.num_rows;
    end

    always_comb
    begin
        unique case (cfg.key_axis)
            AXIS_J:  key = coord_j;
            AXIS_K:  key = coord_k;
            default: key = coord_i;
        endcase
    end

    assign bad = (key >= COORD_W'(rows)) ||
                 (({1'b0, key} + 17'd1) < 17'(next_slot_reg));

    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;

    // Pointers carry the low bits of the count.
    assign ext_a = {{PTR_W{1'b0}}, count_reg};
    assign ext_b = {{PTR_W{1'b0}}, count_inc};

    always_comb
    begin
        cmd.start      = next_slot_reg;
        cmd.ptr_a      = ext_a[PTR_W-1:0];
        cmd.ptr_b      = ext_b[PTR_W-1:0];
        cmd.bad        = bad;
        next_slot_next = next_slot_reg;
        count_next     = count_reg;
        push           = 1'b0;
        if (bad)
        begin
            // A dropped tuple reports once, or closes the stream if it is the last one.
            // When the row count has shrunk below the pending slot, the close is a
            // single report at the pending slot.
            if (!last_item)
                cmd.stop = next_slot_reg;
            else if (next_slot_reg > rows)
                cmd.stop = next_slot_reg;
            else
                cmd.stop = rows;
            cmd.split = cmd.stop;
            push      = accept;
            if (last_item)
            begin
                next_slot_next = '0;
                count_next     = '0;
            end
        end
        else
        begin
            cmd.stop  = last_item ? rows : key[SLOT_W-1:0];
            cmd.split = key[SLOT_W-1:0];
            // A repeated key that is not last produces no results.
            push      = accept && (last_item || (key[SLOT_W-1:0] >= next_slot_reg));
            if (last_item)
            begin
                next_slot_next = '0;
                count_next     = '0;
            end
            else
            begin
                next_slot_next = key[SLOT_W-1:0] + 1'b1;
                count_next     = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_slot_reg <= '0;
            count_reg     <= '0;
        end
        else if (accept)
        begin
            next_slot_reg <= next_slot_next;
            count_reg     <= count_next;
        end
    end

endmodule

@@ src/srpb_queue.sv @@
// Short command queue between the front end and the back end.
// Depends on srpb_pkg.
module srpb_queue #(
    parameter int DEPTH = srpb_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  srpb_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output srpb_pkg::cmd_t      head_cmd,
    output srpb_pkg::q_status_t status
);
    import srpb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] fill_reg;
    logic          do_push, do_pop;

    assign status.full  = (fill_reg == CW'(DEPTH));
    assign status.empty = (fill_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

@@ src/srpb_back.sv @@
// Back end: walks each queued run one slot per cycle into a registered output, holding while out_ready is low.
// Depends on srpb_pkg.
module srpb_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  srpb_pkg::cmd_t              head_cmd,
    input  srpb_pkg::q_status_t         q_status,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [srpb_pkg::SLOT_W-1:0] slot,
    output logic [srpb_pkg::PTR_W-1:0]  pointer,
    output logic                        run_end,
    output logic                        bad_key
);
    import srpb_pkg::*;

    cmd_t              cmd_reg;
    logic              active_reg;
    logic [SLOT_W-1:0] cur_reg;
    logic              valid_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [PTR_W-1:0]  pointer_reg;
    logic              run_end_reg;
    logic              bad_reg;
    logic              advance, finishing, load;

    assign advance   = !valid_reg || out_ready;
    assign finishing = active_reg && advance && (cur_reg == cmd_reg.stop);
    assign load      = !q_status.empty && (!active_reg || finishing);
    assign pop       = load;

    assign out_valid = valid_reg;
    assign slot      = slot_reg;
    assign pointer   = pointer_reg;
    assign run_end   = run_end_reg;
    assign bad_key   = bad_reg;

    always_ff @(posedge clk)
    begin
        if (advance && active_reg)
        begin
            slot_reg    <= cur_reg;
            pointer_reg <= (cur_reg > cmd_reg.split) ? cmd_reg.ptr_b : cmd_reg.ptr_a;
            run_end_reg <= (cur_reg == cmd_reg.stop);
            bad_reg     <= cmd_reg.bad;
        end
        if (load)
            cmd_reg <= head_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cur_reg    <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
                valid_reg <= active_reg;
            if (load)
            begin
                active_reg <= 1'b1;
                cur_reg    <= head_cmd.start;
            end
            else if (finishing)
                active_reg <= 1'b0;
            else if (advance && active_reg)
                cur_reg <= cur_reg + 1'b1;
        end
    end

endmodule

@@ src/sparse_row_pointer_builder_top.sv @@
// Top level of the sparse row pointer builder: configuration registers and the
// front end, command queue and back end. Depends on srpb_pkg and all srpb modules.
//
// The block builds a CSR row pointer array from coordinate tuples that arrive
// sorted by the row key. For every tuple it writes each pending pointer slot up
// to and including the tuple's key with the number of tuples seen so far; the
// tuple marked last also fills the remaining slots through num_rows with the
// total, so a stream yields num_rows+1 entries and then the block is ready for
// a new stream. A key at or above num_rows, or below the previous key, is
// dropped without being counted and reported with bad_key set (on the last
// tuple the stream is still closed). The tuple count saturates at all ones.
// Timing: the front end accepts one tuple per cycle whenever the command queue
// (QUEUE_DEPTH entries) has room, and a tuple with a repeated key costs nothing
// further. The back end produces one result per cycle while m_tready allows,
// through an output register, so a tuple that opens new slots occupies the back
// end until all its results (up to num_rows+1 on the last tuple) are out; the
// output side sets the sustained rate once the queue has filled. Configuration
// writes must happen only while the block is idle.
module sparse_row_pointer_builder_top #(
    parameter int MAX_ROWS    = srpb_pkg::DEF_MAX_ROWS,
    parameter int COUNT_WIDTH = srpb_pkg::DEF_COUNT_WIDTH,
    parameter int QUEUE_DEPTH = srpb_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port.
    input  logic                             cfg_wen,
    input  logic [srpb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [srpb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Tuple requests in.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [srpb_pkg::IN_DATA_W-1:0]   s_tdata,  // coord_i, coord_j, coord_k
    input  logic                             s_tlast,  // last_item
    // Row pointer requests out.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [srpb_pkg::OUT_DATA_W-1:0]  m_tdata,  // slot, pointer, two zero bits
    output logic                             m_tlast,  // run_end
    output logic                             m_tuser   // bad_key
);
    import srpb_pkg::*;

    cfg_t              cfg_reg;
    cmd_t              front_cmd, head_cmd;
    q_status_t         q_status;
    logic              push, pop;
    logic [SLOT_W-1:0] slot;
    logic [PTR_W-1:0]  pointer;

    // Register writes; the index is one bit wide, so every write lands on a register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_rows <= NUM_ROWS_RESET;
            cfg_reg.key_axis <= AXIS_I;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index_t'(cfg_addr))
                REG_NUM_ROWS: cfg_reg.num_rows <= cfg_wdata[SLOT_W-1:0];
                REG_KEY_AXIS: cfg_reg.key_axis <= cfg_wdata[AXIS_W-1:0];
            endcase
        end
    end

    srpb_front #(
        .MAX_ROWS    (MAX_ROWS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .coord_i   (s_tdata[COORD_W-1:0]),
        .coord_j   (s_tdata[2*COORD_W-1:COORD_W]),
        .coord_k   (s_tdata[3*COORD_W-1:2*COORD_W]),
        .last_item (s_tlast),
        .q_status  (q_status),
        .push      (push),
        .cmd       (front_cmd)
    );

    srpb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    srpb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .slot      (slot),
        .pointer   (pointer),
        .run_end   (m_tlast),
        .bad_key   (m_tuser)
    );

    assign m_tdata = {{(OUT_DATA_W - SLOT_W - PTR_W){1'b0}}, pointer, slot};

endmodule
